### rtl/core/ffsa_pkg.sv
// ffsa_pkg: shared types and constants of the first fit space allocator
// payload structs, controller states, datapath operations, status group
// used by ffsa_ctrl, ffsa_dp and first_fit_space_allocator
package ffsa_pkg;

   localparam logic [15:0] LOT_RESET   = 16'hFFFF;
   localparam logic [19:0] CHARGE_MAX  = 20'hFFFFF;
   localparam logic [19:0] CHARGE_STEP = 20'd10;
   localparam logic [0:0]  REG_LOT     = 1'b0;
   localparam logic        KIND_ARRIVAL   = 1'b0;
   localparam logic        KIND_DEPARTURE = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] key;
      logic [15:0] req_length;
   } req_type;

   typedef struct packed {
      logic        placed;
      logic [15:0] start_offset;
      logic        released;
      logic [19:0] total_charge;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_H_RD, ST_H_CHK, ST_H_END, ST_A_RD, ST_A_CHK,
      ST_SD_CHK, ST_SD_RD, ST_SD_WR, ST_SD_END, ST_COMMIT, ST_D_RD, ST_D_CHK,
      ST_D_DEC, ST_SU_CHK, ST_SU_RD, ST_SU_WR, ST_SU_END, ST_REL, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_INIT, OP_LOAD, OP_H_RD, OP_H_CHK, OP_H_END, OP_A_RD, OP_A_CHK,
      OP_SD_RD, OP_SD_WR, OP_SD_END, OP_COMMIT, OP_D_RD, OP_D_CHK, OP_D_DEC,
      OP_SU_RD, OP_SU_WR, OP_SU_END, OP_REL, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic is_dep;
      logic cfg_wr;
      logic out_free;
      logic h_match;
      logic h_last;
      logic held;
      logic slot_ok;
      logic q_zero;
      logic cnt_zero;
      logic a_fit;
      logic a_exact;
      logic f_last;
      logic sd_more;
      logic d_found;
      logic jp;
      logic jn;
      logic list_full;
      logic su_more;
   } sts_type;

endpackage

### rtl/core/ffsa_ram.sv
// ffsa_ram: generic single write, single read RAM with registered read data
// no dependencies
module ffsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/ffsa_ctrl.sv
// ffsa_ctrl: controller state machine sequencing table scans and list shifts
// depends on ffsa_pkg
module ffsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffsa_pkg::sts_type sts,
   output ffsa_pkg::ctl_type ctl
);

   ffsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffsa_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl.op    = ffsa_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ffsa_pkg::ST_INIT: begin
            ctl.op   = ffsa_pkg::OP_INIT;
            state_in = ffsa_pkg::ST_IDLE;
         end
         ffsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op   = ffsa_pkg::OP_LOAD;
               state_in = ffsa_pkg::ST_H_RD;
            end
         end
         ffsa_pkg::ST_H_RD: begin
            ctl.op   = ffsa_pkg::OP_H_RD;
            state_in = ffsa_pkg::ST_H_CHK;
         end
         ffsa_pkg::ST_H_CHK: begin
            ctl.op   = ffsa_pkg::OP_H_CHK;
            state_in = (sts.h_match || sts.h_last) ? ffsa_pkg::ST_H_END : ffsa_pkg::ST_H_RD;
         end
         ffsa_pkg::ST_H_END: begin
            ctl.op = ffsa_pkg::OP_H_END;
            if (!sts.is_dep) begin
               if ((!sts.held && !sts.slot_ok) || sts.q_zero || sts.cnt_zero) begin
                  state_in = ffsa_pkg::ST_DONE;
               end else begin
                  state_in = ffsa_pkg::ST_A_RD;
               end
            end else if (!sts.held) begin
               state_in = ffsa_pkg::ST_DONE;
            end else if (sts.cnt_zero) begin
               state_in = ffsa_pkg::ST_D_DEC;
            end else begin
               state_in = ffsa_pkg::ST_D_RD;
            end
         end
         ffsa_pkg::ST_A_RD: begin
            ctl.op   = ffsa_pkg::OP_A_RD;
            state_in = ffsa_pkg::ST_A_CHK;
         end
         ffsa_pkg::ST_A_CHK: begin
            ctl.op = ffsa_pkg::OP_A_CHK;
            if (sts.a_fit) begin
               state_in = sts.a_exact ? ffsa_pkg::ST_SD_CHK : ffsa_pkg::ST_COMMIT;
            end else if (sts.f_last) begin
               state_in = ffsa_pkg::ST_DONE;
            end else begin
               state_in = ffsa_pkg::ST_A_RD;
            end
         end
         ffsa_pkg::ST_SD_CHK: begin
            state_in = sts.sd_more ? ffsa_pkg::ST_SD_RD : ffsa_pkg::ST_SD_END;
         end
         ffsa_pkg::ST_SD_RD: begin
            ctl.op   = ffsa_pkg::OP_SD_RD;
            state_in = ffsa_pkg::ST_SD_WR;
         end
         ffsa_pkg::ST_SD_WR: begin
            ctl.op   = ffsa_pkg::OP_SD_WR;
            state_in = ffsa_pkg::ST_SD_CHK;
         end
         ffsa_pkg::ST_SD_END: begin
            ctl.op   = ffsa_pkg::OP_SD_END;
            state_in = sts.is_dep ? ffsa_pkg::ST_REL : ffsa_pkg::ST_COMMIT;
         end
         ffsa_pkg::ST_COMMIT: begin
            ctl.op   = ffsa_pkg::OP_COMMIT;
            state_in = ffsa_pkg::ST_DONE;
         end
         ffsa_pkg::ST_D_RD: begin
            ctl.op   = ffsa_pkg::OP_D_RD;
            state_in = ffsa_pkg::ST_D_CHK;
         end
         ffsa_pkg::ST_D_CHK: begin
            ctl.op   = ffsa_pkg::OP_D_CHK;
            state_in = (sts.d_found || sts.f_last) ? ffsa_pkg::ST_D_DEC : ffsa_pkg::ST_D_RD;
         end
         ffsa_pkg::ST_D_DEC: begin
            ctl.op = ffsa_pkg::OP_D_DEC;
            if (sts.jp && sts.jn) begin
               state_in = ffsa_pkg::ST_SD_CHK;
            end else if (sts.jp || sts.jn) begin
               state_in = ffsa_pkg::ST_REL;
            end else if (sts.list_full) begin
               state_in = ffsa_pkg::ST_DONE;
            end else begin
               state_in = ffsa_pkg::ST_SU_CHK;
            end
         end
         ffsa_pkg::ST_SU_CHK: begin
            state_in = sts.su_more ? ffsa_pkg::ST_SU_RD : ffsa_pkg::ST_SU_END;
         end
         ffsa_pkg::ST_SU_RD: begin
            ctl.op   = ffsa_pkg::OP_SU_RD;
            state_in = ffsa_pkg::ST_SU_WR;
         end
         ffsa_pkg::ST_SU_WR: begin
            ctl.op   = ffsa_pkg::OP_SU_WR;
            state_in = ffsa_pkg::ST_SU_CHK;
         end
         ffsa_pkg::ST_SU_END: begin
            ctl.op   = ffsa_pkg::OP_SU_END;
            state_in = ffsa_pkg::ST_REL;
         end
         ffsa_pkg::ST_REL: begin
            ctl.op   = ffsa_pkg::OP_REL;
            state_in = ffsa_pkg::ST_DONE;
         end
         ffsa_pkg::ST_DONE: begin
            if (sts.out_free) begin
               ctl.op   = ffsa_pkg::OP_OUT;
               state_in = ffsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffsa_pkg::ST_INIT;
         end
      endcase
      if (sts.cfg_wr) begin
         state_in = ffsa_pkg::ST_INIT;
      end
   end

endmodule

### rtl/core/ffsa_dp.sv
// ffsa_dp: datapath with holder table, free segment list, charge and result register
// depends on ffsa_pkg and ffsa_ram
module ffsa_dp #(
   parameter int MAX_HOLDERS = 64,
   parameter int POS_BITS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  ffsa_pkg::ctl_type ctl,
   output ffsa_pkg::sts_type sts,
   input  ffsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffsa_pkg::rsp_type rsp_data,
   input  logic              lot_wr,
   input  logic [15:0]       lot_wdata,
   output logic [15:0]       lot_value
);

   localparam int FREE_DEPTH = MAX_HOLDERS + 1;
   localparam int HB = $clog2(MAX_HOLDERS);
   localparam int FB = $clog2(FREE_DEPTH);
   localparam int CB = $clog2(FREE_DEPTH + 1);
   localparam int PB = POS_BITS;
   localparam int HW = 16 + 2 * PB;

   logic [15:0]          lot_ff;
   logic                 kind_ff, kind_in;
   logic [15:0]          key_ff, key_in;
   logic [PB-1:0]        q_ff, q_in;
   logic [CB-1:0]        idx_ff, idx_in;
   logic [CB-1:0]        cnt_ff, cnt_in;
   logic [CB-1:0]        pos_ff, pos_in;
   logic [MAX_HOLDERS-1:0] valid_ff, valid_in;
   logic                 held_ff, held_in;
   logic                 slot_ok_ff, slot_ok_in;
   logic [HB-1:0]        hit_ff, hit_in;
   logic [HB-1:0]        slot_ff, slot_in;
   logic [PB-1:0]        hs_ff, hs_in, hl_ff, hl_in;
   logic [PB-1:0]        ps_ff, ps_in, pl_ff, pl_in;
   logic [PB-1:0]        cs_ff, cs_in, cl_ff, cl_in;
   logic                 cur_ok_ff, cur_ok_in;
   logic [PB-1:0]        res_start_ff, res_start_in;
   logic                 placed_ff, placed_in;
   logic                 released_ff, released_in;
   logic [19:0]          charge_ff, charge_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 h_we;
   logic [HB-1:0]        h_waddr, h_raddr;
   logic [HW-1:0]        h_wdata, h_rdata;
   logic                 f_we;
   logic [FB-1:0]        f_waddr, f_raddr;
   logic [2*PB-1:0]      f_wdata, f_rdata;

   logic [15:0]          hd_key;
   logic [PB-1:0]        hd_start, hd_len, fd_start, fd_len;
   logic [CB:0]          idx_p1;

   ffsa_ram #(.WIDTH(HW), .DEPTH(MAX_HOLDERS)) u_hold_ram (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   ffsa_ram #(.WIDTH(2 * PB), .DEPTH(FREE_DEPTH)) u_free_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   assign {hd_key, hd_start, hd_len} = h_rdata;
   assign {fd_start, fd_len} = f_rdata;
   assign idx_p1 = {1'b0, idx_ff} + (CB + 1)'(1);

   always_comb begin
      sts.is_dep    = (kind_ff == ffsa_pkg::KIND_DEPARTURE);
      sts.cfg_wr    = lot_wr;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.h_match   = valid_ff[idx_ff[HB-1:0]] && (hd_key == key_ff);
      sts.h_last    = (idx_ff == CB'(MAX_HOLDERS - 1));
      sts.held      = held_ff;
      sts.slot_ok   = slot_ok_ff;
      sts.q_zero    = (q_ff == '0);
      sts.cnt_zero  = (cnt_ff == '0);
      sts.a_fit     = (fd_len >= q_ff);
      sts.a_exact   = (fd_len == q_ff);
      sts.f_last    = (idx_p1 == {1'b0, cnt_ff});
      sts.sd_more   = (idx_p1 < {1'b0, cnt_ff});
      sts.d_found   = (fd_start >= hs_ff);
      sts.jp        = (idx_ff != '0) &&
                      (({1'b0, ps_ff} + {1'b0, pl_ff}) == {1'b0, hs_ff});
      sts.jn        = cur_ok_ff && (({1'b0, hs_ff} + {1'b0, hl_ff}) == {1'b0, cs_ff});
      sts.list_full = (cnt_ff >= CB'(FREE_DEPTH));
      sts.su_more   = (idx_ff > pos_ff);
   end

   always_comb begin
      kind_in      = kind_ff;
      key_in       = key_ff;
      q_in         = q_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      valid_in     = valid_ff;
      held_in      = held_ff;
      slot_ok_in   = slot_ok_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      hs_in        = hs_ff;
      hl_in        = hl_ff;
      ps_in        = ps_ff;
      pl_in        = pl_ff;
      cs_in        = cs_ff;
      cl_in        = cl_ff;
      cur_ok_in    = cur_ok_ff;
      res_start_in = res_start_ff;
      placed_in    = placed_ff;
      released_in  = released_ff;
      charge_in    = charge_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      h_we    = 1'b0;
      h_waddr = slot_ff;
      h_wdata = {key_ff, res_start_ff, q_ff};
      h_raddr = idx_ff[HB-1:0];
      f_we    = 1'b0;
      f_waddr = idx_ff[FB-1:0];
      f_wdata = f_rdata;
      f_raddr = idx_ff[FB-1:0];
      case (ctl.op)
         ffsa_pkg::OP_INIT: begin
            f_we      = 1'b1;
            f_waddr   = '0;
            f_wdata   = {PB'(0), PB'(lot_ff)};
            cnt_in    = (lot_ff != '0) ? CB'(1) : CB'(0);
            valid_in  = '0;
            charge_in = '0;
         end
         ffsa_pkg::OP_LOAD: begin
            kind_in      = req_data.kind;
            key_in       = req_data.key;
            q_in         = PB'(req_data.req_length);
            idx_in       = '0;
            held_in      = 1'b0;
            slot_ok_in   = 1'b0;
            placed_in    = 1'b0;
            released_in  = 1'b0;
            res_start_in = '0;
         end
         ffsa_pkg::OP_H_CHK: begin
            if (sts.h_match) begin
               held_in = 1'b1;
               hit_in  = idx_ff[HB-1:0];
               hs_in   = hd_start;
               hl_in   = hd_len;
            end
            if (!valid_ff[idx_ff[HB-1:0]] && !slot_ok_ff) begin
               slot_ok_in = 1'b1;
               slot_in    = idx_ff[HB-1:0];
            end
            idx_in = CB'(idx_p1);
         end
         ffsa_pkg::OP_H_END: begin
            idx_in    = '0;
            cur_ok_in = 1'b0;
         end
         ffsa_pkg::OP_A_CHK: begin
            if (sts.a_fit) begin
               res_start_in = fd_start;
               if (!sts.a_exact) begin
                  f_we    = 1'b1;
                  f_wdata = {PB'(fd_start + q_ff), PB'(fd_len - q_ff)};
               end
            end else begin
               idx_in = CB'(idx_p1);
            end
         end
         ffsa_pkg::OP_SD_RD: begin
            f_raddr = idx_p1[FB-1:0];
         end
         ffsa_pkg::OP_SD_WR: begin
            f_we   = 1'b1;
            idx_in = CB'(idx_p1);
         end
         ffsa_pkg::OP_SD_END: begin
            cnt_in = cnt_ff - CB'(1);
         end
         ffsa_pkg::OP_COMMIT: begin
            if (!held_ff) begin
               h_we               = 1'b1;
               valid_in[slot_ff]  = 1'b1;
            end
            charge_in = (charge_ff > (ffsa_pkg::CHARGE_MAX - ffsa_pkg::CHARGE_STEP)) ?
                        ffsa_pkg::CHARGE_MAX : charge_ff + ffsa_pkg::CHARGE_STEP;
            placed_in = 1'b1;
         end
         ffsa_pkg::OP_D_CHK: begin
            if (sts.d_found) begin
               cs_in     = fd_start;
               cl_in     = fd_len;
               cur_ok_in = 1'b1;
            end else begin
               ps_in  = fd_start;
               pl_in  = fd_len;
               idx_in = CB'(idx_p1);
            end
         end
         ffsa_pkg::OP_D_DEC: begin
            if (sts.jp) begin
               f_we    = 1'b1;
               f_waddr = FB'(idx_ff - CB'(1));
               f_wdata = sts.jn ? {ps_ff, PB'(pl_ff + hl_ff + cl_ff)} : {ps_ff, PB'(pl_ff + hl_ff)};
            end else if (sts.jn) begin
               f_we    = 1'b1;
               f_wdata = {hs_ff, PB'(cl_ff + hl_ff)};
            end else if (!sts.list_full) begin
               pos_in = idx_ff;
               idx_in = cnt_ff;
            end
         end
         ffsa_pkg::OP_SU_RD: begin
            f_raddr = FB'(idx_ff - CB'(1));
         end
         ffsa_pkg::OP_SU_WR: begin
            f_we   = 1'b1;
            idx_in = idx_ff - CB'(1);
         end
         ffsa_pkg::OP_SU_END: begin
            f_we    = 1'b1;
            f_waddr = pos_ff[FB-1:0];
            f_wdata = {hs_ff, hl_ff};
            cnt_in  = cnt_ff + CB'(1);
         end
         ffsa_pkg::OP_REL: begin
            valid_in[hit_ff] = 1'b0;
            released_in      = 1'b1;
         end
         ffsa_pkg::OP_OUT: begin
            rsp_valid_in          = 1'b1;
            rsp_in.placed         = placed_ff;
            rsp_in.start_offset   = 16'(res_start_ff);
            rsp_in.released       = released_ff;
            rsp_in.total_charge   = charge_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lot_ff       <= ffsa_pkg::LOT_RESET;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         charge_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         kind_ff      <= 1'b0;
         held_ff      <= 1'b0;
         slot_ok_ff   <= 1'b0;
         cur_ok_ff    <= 1'b0;
         placed_ff    <= 1'b0;
         released_ff  <= 1'b0;
      end else begin
         lot_ff       <= lot_wr ? lot_wdata : lot_ff;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         charge_ff    <= charge_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         kind_ff      <= kind_in;
         held_ff      <= held_in;
         slot_ok_ff   <= slot_ok_in;
         cur_ok_ff    <= cur_ok_in;
         placed_ff    <= placed_in;
         released_ff  <= released_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      q_ff         <= q_in;
      pos_ff       <= pos_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
      hs_ff        <= hs_in;
      hl_ff        <= hl_in;
      ps_ff        <= ps_in;
      pl_ff        <= pl_in;
      cs_ff        <= cs_in;
      cl_ff        <= cl_in;
      res_start_ff <= res_start_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign lot_value = lot_ff;

endmodule

### rtl/core/first_fit_space_allocator.sv
// first_fit_space_allocator: top level, APB register port, controller and datapath
// an item's processing time grows with the holder entries scanned, the free segments walked
// and the free segments shifted
// one item at a time; a result waits in the output register while the next item is taken
// reset and any lot_length write clear the holder table, charge and free list (via ST_INIT)
// depends on ffsa_pkg, ffsa_ctrl, ffsa_dp, ffsa_ram
module first_fit_space_allocator #(
   parameter int MAX_HOLDERS = 64,
   parameter int POS_BITS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffsa_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   ffsa_pkg::ctl_type ctl;
   ffsa_pkg::sts_type sts;
   logic              lot_wr;
   logic [15:0]       lot_value;

   assign pready = 1'b1;
   assign lot_wr = psel && penable && pwrite && (paddr[2] == ffsa_pkg::REG_LOT);
   assign prdata = (paddr[2] == ffsa_pkg::REG_LOT) ? {16'h0000, lot_value} : 32'h0000_0000;

   ffsa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .ctl(ctl)
   );

   ffsa_dp #(.MAX_HOLDERS(MAX_HOLDERS), .POS_BITS(POS_BITS)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .lot_wr(lot_wr), .lot_wdata(pwdata[15:0]), .lot_value(lot_value)
   );

endmodule

### tb/tb.sv
// tb: self-checking testbench for first_fit_space_allocator
// drives arrivals and departures with random gaps, checks every result against a local predictor
// depends on ffsa_pkg and first_fit_space_allocator
`timescale 1ns / 1ps

module tb;

   localparam int HOLDERS = 64;
   localparam int SEG_DEPTH = HOLDERS + 1;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ffsa_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ffsa_pkg::rsp_type rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   first_fit_space_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // allocator shadow state
   int unsigned lot_len;
   int unsigned seg_start [SEG_DEPTH];
   int unsigned seg_len [SEG_DEPTH];
   int          seg_cnt;
   bit          hold_valid [HOLDERS];
   int unsigned hold_key [HOLDERS];
   int unsigned hold_start [HOLDERS];
   int unsigned hold_len [HOLDERS];
   int unsigned charge;

   ffsa_pkg::req_type pending_items[$];
   ffsa_pkg::rsp_type expected_rsps[$];
   int                errors;
   bit                req_taken;

   function automatic void clear_space();
      for (int i = 0; i < HOLDERS; i++) begin
         hold_valid[i] = 0;
      end
      charge = 0;
      seg_cnt = (lot_len != 0) ? 1 : 0;
      seg_start[0] = 0;
      seg_len[0] = lot_len;
   endfunction

   function automatic int find_holder(int unsigned k);
      for (int i = 0; i < HOLDERS; i++) begin
         if (hold_valid[i] && hold_key[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic void drop_segment(int i);
      for (int j = i; j + 1 < seg_cnt; j++) begin
         seg_start[j] = seg_start[j + 1];
         seg_len[j] = seg_len[j + 1];
      end
      seg_cnt--;
   endfunction

   function automatic ffsa_pkg::rsp_type allocate_or_free(ffsa_pkg::req_type it);
      ffsa_pkg::rsp_type r;
      int                h;
      int                slot;
      int                i;
      int unsigned       s;
      int unsigned       ln;
      int unsigned       q;
      bit                jp;
      bit                jn;
      r = '0;
      q = 32'(it.req_length);
      h = find_holder(32'(it.key));
      if (it.kind == ffsa_pkg::KIND_ARRIVAL) begin
         slot = -1;
         if (h < 0) begin
            for (int k = 0; k < HOLDERS; k++) begin
               if (!hold_valid[k] && slot < 0) slot = k;
            end
         end
         if ((h >= 0 || slot >= 0) && q != 0) begin
            i = 0;
            while (i < seg_cnt && seg_len[i] < q) i++;
            if (i < seg_cnt) begin
               s = seg_start[i];
               if (seg_len[i] > q) begin
                  seg_start[i] += q;
                  seg_len[i] -= q;
               end else begin
                  drop_segment(i);
               end
               if (h < 0) begin
                  hold_valid[slot] = 1;
                  hold_key[slot] = 32'(it.key);
                  hold_start[slot] = s;
                  hold_len[slot] = q;
               end
               charge = (charge > 1048575 - 10) ? 1048575 : charge + 10;
               r.placed = 1'b1;
               r.start_offset = s[15:0];
            end
         end
      end else if (h >= 0) begin
         s = hold_start[h];
         ln = hold_len[h];
         i = 0;
         while (i < seg_cnt && seg_start[i] < s) i++;
         jp = (i > 0) && (seg_start[i - 1] + seg_len[i - 1] == s);
         jn = (i < seg_cnt) && (s + ln == seg_start[i]);
         if (jp && jn) begin
            seg_len[i - 1] += ln + seg_len[i];
            drop_segment(i);
            r.released = 1'b1;
         end else if (jp) begin
            seg_len[i - 1] += ln;
            r.released = 1'b1;
         end else if (jn) begin
            seg_start[i] = s;
            seg_len[i] += ln;
            r.released = 1'b1;
         end else if (seg_cnt < SEG_DEPTH) begin
            for (int j = seg_cnt; j > i; j--) begin
               seg_start[j] = seg_start[j - 1];
               seg_len[j] = seg_len[j - 1];
            end
            seg_start[i] = s;
            seg_len[i] = ln;
            seg_cnt++;
            r.released = 1'b1;
         end
         if (r.released) hold_valid[h] = 0;
      end
      r.total_charge = charge[19:0];
      return r;
   endfunction

   // sender: bursts with gaps
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern changes mode now and then
   int stall_mode;
   int mode_left;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left <= $urandom_range(30, 200);
         stall_mode <= $urandom_range(0, 2);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // monitor: predict on request transfer, check on result transfer
   always @(posedge clock) begin
      ffsa_pkg::rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         expected_rsps.push_back(allocate_or_free(req_data));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.placed !== want.placed || rsp_data.start_offset !== want.start_offset
                || rsp_data.released !== want.released
                || rsp_data.total_charge !== want.total_charge) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   task automatic write_lot(input int unsigned v);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {ffsa_pkg::REG_LOT, 2'b00};
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      lot_len = v & 32'h0000_FFFF;
      clear_space();
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic ffsa_pkg::req_type make_item(bit kind, int unsigned k, int unsigned ln);
      ffsa_pkg::req_type it;
      it.kind = kind;
      it.key = 16'(k);
      it.req_length = 16'(ln);
      return it;
   endfunction

   task automatic random_phase(int n, int keys, int max_len);
      int unsigned k;
      int unsigned ln;
      for (int i = 0; i < n; i++) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, keys - 1);
         case ($urandom_range(0, 19))
            0: ln = 0;
            1: ln = $urandom_range(1, 65535);
            default: ln = $urandom_range(1, max_len);
         endcase
         pending_items.push_back(make_item($urandom_range(0, 9) < 4, k, ln));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      errors = 0;
      burst_left = 0;
      gap_left = 0;
      stall_mode = 0;
      mode_left = 0;
      req_taken = 1'b0;
      lot_len = 32'(ffsa_pkg::LOT_RESET);
      clear_space();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (5) @(posedge clock);

      // directed: extremes and corner cases on the reset lot
      pending_items.push_back(make_item(ffsa_pkg::KIND_DEPARTURE, 16'h1234, 16'd5));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0000, 16'd0));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'hFFFF, 16'hFFFF));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0001, 16'd1));
      pending_items.push_back(make_item(ffsa_pkg::KIND_DEPARTURE, 16'hFFFF, 16'hFFFF));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0000, 16'd100));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0000, 16'd50));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0002, 16'd100));
      pending_items.push_back(make_item(ffsa_pkg::KIND_DEPARTURE, 16'h0000, 16'd0));
      pending_items.push_back(make_item(ffsa_pkg::KIND_DEPARTURE, 16'h0000, 16'd0));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0003, 16'd10));
      pending_items.push_back(make_item(ffsa_pkg::KIND_DEPARTURE, 16'h0002, 16'd0));
      pending_items.push_back(make_item(ffsa_pkg::KIND_DEPARTURE, 16'h0003, 16'd0));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h8000, 16'hFFFF));
      wait_drained();

      write_lot(1);
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0005, 16'd2));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0005, 16'd1));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0006, 16'd1));
      pending_items.push_back(make_item(ffsa_pkg::KIND_DEPARTURE, 16'h0005, 16'd0));
      pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 16'h0006, 16'd1));
      wait_drained();

      // many holders: fills the holder table
      write_lot(65535);
      for (int i = 0; i < 70; i++) begin
         pending_items.push_back(make_item(ffsa_pkg::KIND_ARRIVAL, 100 + i,
                                           $urandom_range(1, 8)));
      end
      random_phase(200, 120, 30);
      wait_drained();

      // tight lot with few keys: fragmentation and reuse of held keys
      write_lot(300);
      random_phase(350, 16, 12);
      wait_drained();

      write_lot(65535);
      random_phase(250, 90, 2000);
      wait_drained();

      if (expected_rsps.size() == 0 && errors == 0) begin
         $display("first_fit_space_allocator test passed");
      end else begin
         $display("first_fit_space_allocator test failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("first_fit_space_allocator test failed");
      $finish;
   end

endmodule
